// File: sv/pocj_pkg.sv
package pocj_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int REGION_W   = 2;
    localparam int TAIL_DEPTH = 8192;
    localparam int TAIL_AW    = $clog2(TAIL_DEPTH);
    localparam int MAX_CH     = 8;
    localparam int CH_W       = $clog2(MAX_CH);
    localparam int CNT_CH_W   = 4;
    localparam int FRAME_W    = 12;
    localparam int OVL_W      = 13;
    localparam int DEN_W      = OVL_W + 1;
    localparam int GAIN_W     = FRAME_W + 1;
    localparam int FMT_W      = 2;

    // mix arithmetic
    localparam int ACC_W      = 47;
    localparam int MAG_W      = 46;
    localparam int REM_W      = DEN_W - 1;
    localparam int MUL_STEPS  = DEN_W;
    localparam int DIV_STEPS  = MAG_W / 2;
    localparam int STEP_CNT_W = 5;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 2'd2;

    localparam logic [REGION_W-1:0] REGION_BODY = 2'd0;
    localparam logic [REGION_W-1:0] REGION_HEAD = 2'd1;
    localparam logic [REGION_W-1:0] REGION_TAIL = 2'd2;
    // spare code, passed through like body
    localparam logic [REGION_W-1:0] REGION_RSVD = 2'd3;

    localparam logic [OVL_W-1:0]    OVL_RESET = 13'd1;
    localparam logic [CNT_CH_W-1:0] CH_RESET  = 4'd2;

    typedef enum logic [FMT_W-1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S24 = 2'd2,
        FMT_S32 = 2'd3
    } t_fmt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_LOAD,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_ROUND,
        ST_SAT
    } t_state;

    function automatic logic [SAMPLE_W-1:0] fmt_mask(input t_fmt fmt);
        logic [SAMPLE_W-1:0] m;
        unique case (fmt)
            FMT_U8:  m = 32'h0000_00FF;
            FMT_S16: m = 32'h0000_FFFF;
            FMT_S24: m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // raw bits to signed sample units; unsigned 8-bit carries an offset of 128
    function automatic logic signed [SAMPLE_W-1:0] decode(
        input logic [SAMPLE_W-1:0] raw,
        input t_fmt fmt
    );
        logic signed [SAMPLE_W-1:0] v;
        unique case (fmt)
            FMT_U8:  v = {{24{~raw[7]}}, ~raw[7], raw[6:0]};
            FMT_S16: v = {{16{raw[15]}}, raw[15:0]};
            FMT_S24: v = {{8{raw[23]}}, raw[23:0]};
            default: v = raw;
        endcase
        return v;
    endfunction

    // largest positive value of the format
    function automatic logic [MAG_W-1:0] sat_hi(input t_fmt fmt);
        logic [MAG_W-1:0] h;
        unique case (fmt)
            FMT_U8:  h = 46'd127;
            FMT_S16: h = 46'd32767;
            FMT_S24: h = 46'd8388607;
            default: h = 46'd2147483647;
        endcase
        return h;
    endfunction

    function automatic logic [CNT_CH_W-1:0] eff_channels(input logic [CNT_CH_W-1:0] cc);
        logic [CNT_CH_W-1:0] e;
        if (cc == '0) begin
            e = CNT_CH_W'(1);
        end else if (cc > CNT_CH_W'(MAX_CH)) begin
            e = CNT_CH_W'(MAX_CH);
        end else begin
            e = cc;
        end
        return e;
    endfunction

endpackage

// File: sv/pocj_if.sv
interface pocj_in_if;
    logic                                valid;
    logic                                ready;
    logic [pocj_pkg::SAMPLE_W-1:0]       sample_raw;
    logic [pocj_pkg::REGION_W-1:0]       region;
    logic                                part_start;

    modport source(output valid, sample_raw, region, part_start, input ready);
    modport sink(input valid, sample_raw, region, part_start, output ready);
endinterface

interface pocj_out_if;
    logic                                valid;
    logic                                ready;
    logic [pocj_pkg::SAMPLE_W-1:0]       sample_out;
    logic                                clipped;

    modport source(output valid, sample_out, clipped, input ready);
    modport sink(input valid, sample_out, clipped, output ready);
endinterface

interface pocj_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pocj_pkg::CFG_IDX_W-1:0]      index;
    logic [pocj_pkg::CFG_DATA_W-1:0]     data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: sv/pcm_overlap_crossfade_joiner_unit.sv
// Joins overlapping PCM parts with a linear crossfade. Tail beats are written to an
// 8192-entry store without holding the input; body beats pass through masked to
// the format and hold the input until the output register takes them. A head beat is
// mixed with the stored tail sample at the same position as (t*(X+1) + (h-t)*(f+1)) /
// (X+1), rounded half to even and saturated: it holds the input channel from accept
// to result, through a shift-add multiplier that consumes one bit of each gain factor
// per cycle and a restoring divider that retires two quotient bits per cycle. A
// finished result waits in the output register while the next beat is
// taken. The tail store has no reset; a head beat must only read slots written by
// tail beats. Configuration writes are taken at any time and must be issued while
// the block is idle.
module pcm_overlap_crossfade_joiner_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pocj_in_if.sink       i_in,
    pocj_out_if.source    o_out,
    pocj_cfg_if.sink      i_cfg
);

    // configuration
    logic [pocj_pkg::OVL_W-1:0]    r_overlap;
    logic [pocj_pkg::CNT_CH_W-1:0] r_channels;
    pocj_pkg::t_fmt                r_fmt;

    // sequencing
    pocj_pkg::t_state r_state, n_state;
    logic [pocj_pkg::STEP_CNT_W-1:0] r_cnt;
    logic in_acc;
    logic out_free;
    logic load_out;

    // position state
    logic [pocj_pkg::TAIL_AW-1:0] r_tail_idx;
    logic [pocj_pkg::TAIL_AW-1:0] r_head_idx;
    logic [pocj_pkg::FRAME_W-1:0] r_frame_idx;
    logic [pocj_pkg::CH_W-1:0]    r_ch_idx;
    logic [pocj_pkg::TAIL_AW-1:0] tail_base;
    logic [pocj_pkg::TAIL_AW-1:0] head_base;
    logic [pocj_pkg::FRAME_W-1:0] frame_base;
    logic [pocj_pkg::CH_W-1:0]    ch_base;
    logic [pocj_pkg::CNT_CH_W-1:0] ch_next;
    logic [pocj_pkg::SAMPLE_W-1:0] raw_masked;

    // tail store
    logic [pocj_pkg::SAMPLE_W-1:0] r_tail_mem [pocj_pkg::TAIL_DEPTH];
    logic [pocj_pkg::SAMPLE_W-1:0] r_tail_q;

    // datapath
    logic [pocj_pkg::SAMPLE_W-1:0] r_raw;
    logic [pocj_pkg::GAIN_W-1:0]   r_gain;
    logic [pocj_pkg::DEN_W-1:0]    r_den_sh;
    logic [pocj_pkg::DEN_W-1:0]    r_gain_sh;
    logic [pocj_pkg::DEN_W-1:0]    r_divisor;
    logic [pocj_pkg::ACC_W-1:0]    r_mt;
    logic [pocj_pkg::ACC_W-1:0]    r_md;
    logic [pocj_pkg::ACC_W-1:0]    r_acc;
    logic                          r_neg;
    logic [pocj_pkg::MAG_W-1:0]    r_div;
    logic [pocj_pkg::REM_W-1:0]    r_rem;
    logic [pocj_pkg::MAG_W-1:0]    r_q;

    logic signed [pocj_pkg::SAMPLE_W-1:0] t_val;
    logic signed [pocj_pkg::SAMPLE_W-1:0] h_val;
    logic [pocj_pkg::SAMPLE_W:0]   diff;
    logic [pocj_pkg::ACC_W-1:0]    acc_sum;
    logic [pocj_pkg::ACC_W-1:0]    acc_mag;
    logic [pocj_pkg::DEN_W-1:0]    part1;
    logic [pocj_pkg::DEN_W-1:0]    part2;
    logic [pocj_pkg::REM_W-1:0]    rem1;
    logic [pocj_pkg::REM_W-1:0]    rem2;
    logic                          qb1;
    logic                          qb2;
    logic [pocj_pkg::DEN_W-1:0]    rem_x2;
    logic                          round_up;
    logic [pocj_pkg::MAG_W-1:0]    limit;
    logic                          clip;
    logic [pocj_pkg::SAMPLE_W:0]   mag_sel;
    logic [pocj_pkg::SAMPLE_W:0]   v_sat;
    logic [pocj_pkg::SAMPLE_W-1:0] mix_out;

    // output register
    logic                          r_out_valid;
    logic [pocj_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                          r_out_clip;

    assign i_cfg.ready      = 1'b1;
    assign i_in.ready       = (r_state == pocj_pkg::ST_IDLE);
    assign in_acc           = i_in.valid && i_in.ready;
    assign out_free         = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.clipped    = r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlap  <= pocj_pkg::OVL_RESET;
            r_channels <= pocj_pkg::CH_RESET;
            r_fmt      <= pocj_pkg::FMT_S16;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                pocj_pkg::CFG_OVERLAP:  r_overlap  <= i_cfg.data;
                pocj_pkg::CFG_CHANNELS: r_channels <= i_cfg.data[pocj_pkg::CNT_CH_W-1:0];
                pocj_pkg::CFG_FORMAT:   r_fmt      <= pocj_pkg::t_fmt'(i_cfg.data[pocj_pkg::FMT_W-1:0]);
                default: ;
            endcase
        end
    end

    // part start clears all positions before the beat is handled
    always_comb begin
        raw_masked = i_in.sample_raw & pocj_pkg::fmt_mask(r_fmt);
        tail_base  = i_in.part_start ? '0 : r_tail_idx;
        head_base  = i_in.part_start ? '0 : r_head_idx;
        frame_base = i_in.part_start ? '0 : r_frame_idx;
        ch_base    = i_in.part_start ? '0 : r_ch_idx;
        ch_next    = {1'b0, ch_base} + pocj_pkg::CNT_CH_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_idx  <= '0;
            r_head_idx  <= '0;
            r_frame_idx <= '0;
            r_ch_idx    <= '0;
        end else if (in_acc) begin
            r_tail_idx  <= tail_base;
            r_head_idx  <= head_base;
            r_frame_idx <= frame_base;
            r_ch_idx    <= ch_base;
            if (i_in.region == pocj_pkg::REGION_TAIL) begin
                r_tail_idx <= tail_base + pocj_pkg::TAIL_AW'(1);
            end else if (i_in.region == pocj_pkg::REGION_HEAD) begin
                r_head_idx <= head_base + pocj_pkg::TAIL_AW'(1);
                if (ch_next >= pocj_pkg::eff_channels(r_channels)) begin
                    r_ch_idx    <= '0;
                    r_frame_idx <= frame_base + pocj_pkg::FRAME_W'(1);
                end else begin
                    r_ch_idx <= ch_next[pocj_pkg::CH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.region == pocj_pkg::REGION_TAIL) begin
            r_tail_mem[tail_base] <= raw_masked;
        end
        if (in_acc && i_in.region == pocj_pkg::REGION_HEAD) begin
            r_tail_q <= r_tail_mem[head_base];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pocj_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            pocj_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.region == pocj_pkg::REGION_HEAD) begin
                        n_state = pocj_pkg::ST_LOAD;
                    end else if (i_in.region != pocj_pkg::REGION_TAIL) begin
                        n_state = pocj_pkg::ST_PASS;
                    end
                end
            end
            pocj_pkg::ST_PASS, pocj_pkg::ST_SAT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = pocj_pkg::ST_IDLE;
                end
            end
            pocj_pkg::ST_LOAD: n_state = pocj_pkg::ST_MUL;
            pocj_pkg::ST_MUL: begin
                if (r_cnt == pocj_pkg::STEP_CNT_W'(pocj_pkg::MUL_STEPS - 1)) begin
                    n_state = pocj_pkg::ST_ABS;
                end
            end
            pocj_pkg::ST_ABS: n_state = pocj_pkg::ST_DIV;
            pocj_pkg::ST_DIV: begin
                if (r_cnt == pocj_pkg::STEP_CNT_W'(pocj_pkg::DIV_STEPS - 1)) begin
                    n_state = pocj_pkg::ST_ROUND;
                end
            end
            pocj_pkg::ST_ROUND: n_state = pocj_pkg::ST_SAT;
            default: n_state = pocj_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        t_val   = pocj_pkg::decode(r_tail_q, r_fmt);
        h_val   = pocj_pkg::decode(r_raw, r_fmt);
        diff    = {h_val[pocj_pkg::SAMPLE_W-1], h_val} - {t_val[pocj_pkg::SAMPLE_W-1], t_val};
        acc_sum = r_acc + (r_den_sh[0] ? r_mt : '0) + (r_gain_sh[0] ? r_md : '0);
        acc_mag = r_acc[pocj_pkg::ACC_W-1] ? (~r_acc + pocj_pkg::ACC_W'(1)) : r_acc;

        // two restoring divide steps per cycle
        part1 = {r_rem, r_div[pocj_pkg::MAG_W-1]};
        qb1   = (part1 >= r_divisor);
        rem1  = qb1 ? pocj_pkg::REM_W'(part1 - r_divisor) : part1[pocj_pkg::REM_W-1:0];
        part2 = {rem1, r_div[pocj_pkg::MAG_W-2]};
        qb2   = (part2 >= r_divisor);
        rem2  = qb2 ? pocj_pkg::REM_W'(part2 - r_divisor) : part2[pocj_pkg::REM_W-1:0];

        // ties go to the even quotient
        rem_x2   = {r_rem, 1'b0};
        round_up = (rem_x2 > r_divisor) || ((rem_x2 == r_divisor) && r_div[0]);

        limit   = pocj_pkg::sat_hi(r_fmt) + pocj_pkg::MAG_W'(r_neg);
        clip    = (r_q > limit);
        mag_sel = clip ? limit[pocj_pkg::SAMPLE_W:0] : r_q[pocj_pkg::SAMPLE_W:0];
        v_sat   = r_neg ? (~mag_sel + (pocj_pkg::SAMPLE_W+1)'(1)) : mag_sel;
        if (r_fmt == pocj_pkg::FMT_U8) begin
            mix_out = {24'd0, ~v_sat[7], v_sat[6:0]};
        end else begin
            mix_out = v_sat[pocj_pkg::SAMPLE_W-1:0] & pocj_pkg::fmt_mask(r_fmt);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pocj_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_raw  <= raw_masked;
                    r_gain <= {1'b0, frame_base} + pocj_pkg::GAIN_W'(1);
                end
            end
            pocj_pkg::ST_LOAD: begin
                r_mt      <= {{(pocj_pkg::ACC_W - pocj_pkg::SAMPLE_W){t_val[pocj_pkg::SAMPLE_W-1]}},
                              t_val};
                r_md      <= {{(pocj_pkg::ACC_W - pocj_pkg::SAMPLE_W - 1){diff[pocj_pkg::SAMPLE_W]}},
                              diff};
                r_den_sh  <= {1'b0, r_overlap} + pocj_pkg::DEN_W'(1);
                r_divisor <= {1'b0, r_overlap} + pocj_pkg::DEN_W'(1);
                r_gain_sh <= {1'b0, r_gain};
                r_acc     <= '0;
                r_cnt     <= '0;
            end
            pocj_pkg::ST_MUL: begin
                r_acc     <= acc_sum;
                r_mt      <= {r_mt[pocj_pkg::ACC_W-2:0], 1'b0};
                r_md      <= {r_md[pocj_pkg::ACC_W-2:0], 1'b0};
                r_den_sh  <= {1'b0, r_den_sh[pocj_pkg::DEN_W-1:1]};
                r_gain_sh <= {1'b0, r_gain_sh[pocj_pkg::DEN_W-1:1]};
                r_cnt     <= r_cnt + pocj_pkg::STEP_CNT_W'(1);
            end
            pocj_pkg::ST_ABS: begin
                r_neg <= r_acc[pocj_pkg::ACC_W-1];
                r_div <= acc_mag[pocj_pkg::MAG_W-1:0];
                r_rem <= '0;
                r_cnt <= '0;
            end
            pocj_pkg::ST_DIV: begin
                // shift quotient bits in as dividend bits leave
                r_div <= {r_div[pocj_pkg::MAG_W-3:0], qb1, qb2};
                r_rem <= rem2;
                r_cnt <= r_cnt + pocj_pkg::STEP_CNT_W'(1);
            end
            pocj_pkg::ST_ROUND: begin
                r_q <= r_div + pocj_pkg::MAG_W'(round_up);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_state == pocj_pkg::ST_PASS) begin
                r_out_sample <= r_raw;
                r_out_clip   <= 1'b0;
            end else begin
                r_out_sample <= mix_out;
                r_out_clip   <= clip;
            end
        end
    end

endmodule

// File: sv/pocj_checker.sv
module pocj_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic [pocj_pkg::REGION_W-1:0]       i_in_region,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [pocj_pkg::SAMPLE_W-1:0]       i_out_sample,
    input logic                                i_out_clipped
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // a result waits until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample) && $stable(i_out_clipped))
        else $error("stalled result changed");

    // a head beat occupies the mixer, so the input closes right after it
    a_head_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_region == pocj_pkg::REGION_HEAD |=> !i_in_ready)
        else $error("input open while a head beat is being mixed");

    // a tail beat only writes the store and frees the input at once
    a_tail_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_region == pocj_pkg::REGION_TAIL |=> i_in_ready)
        else $error("tail beat held the input");

endmodule

bind pcm_overlap_crossfade_joiner_unit pocj_checker u_pocj_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_region  (i_in.region),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_out_clipped(o_out.clipped)
);

// File: tb/pcm_overlap_crossfade_joiner_unit_tb.sv
module pcm_overlap_crossfade_joiner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT    = 3_000_000;
    localparam int DRAIN_LIMIT  = 20_000;
    localparam int SETTLE_TICKS = 48;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 75;
    localparam int LONG_ITEMS   = 24;

    typedef struct packed {
        logic [pocj_pkg::SAMPLE_W-1:0] sample;
        logic                          clipped;
    } t_mixed_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pocj_in_if  in_if();
    pocj_out_if out_if();
    pocj_cfg_if cfg_if();

    pcm_overlap_crossfade_joiner_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #6 i_clk = ~i_clk;

    // joiner state as seen from outside
    logic [pocj_pkg::OVL_W-1:0]    ovl_frames = pocj_pkg::OVL_RESET;
    logic [pocj_pkg::CNT_CH_W-1:0] ch_count   = pocj_pkg::CH_RESET;
    pocj_pkg::t_fmt                cur_fmt    = pocj_pkg::FMT_S16;
    logic [pocj_pkg::SAMPLE_W-1:0] tail_mem [pocj_pkg::TAIL_DEPTH];
    bit                            slot_written [pocj_pkg::TAIL_DEPTH];
    int                            tail_wr;
    int                            head_rd;
    logic [pocj_pkg::FRAME_W-1:0]  head_frame;
    int                            head_ch;

    t_mixed_beat predicted_samples [$];
    t_mixed_beat want_beat;
    int          fail_count;
    int          cycle_count;
    int          src_idle_pct;
    int          snk_stall_pct;

    function automatic int fmt_bits(input pocj_pkg::t_fmt f);
        case (f)
            pocj_pkg::FMT_U8:  return 8;
            pocj_pkg::FMT_S16: return 16;
            pocj_pkg::FMT_S24: return 24;
            default: return 32;
        endcase
    endfunction

    function automatic logic [pocj_pkg::SAMPLE_W-1:0] fmt_width_mask(input pocj_pkg::t_fmt f);
        return (fmt_bits(f) == 32) ? '1 : ((32'd1 << fmt_bits(f)) - 32'd1);
    endfunction

    function automatic longint to_level(
        input logic [pocj_pkg::SAMPLE_W-1:0] raw,
        input pocj_pkg::t_fmt                f
    );
        case (f)
            pocj_pkg::FMT_U8:  return longint'(raw[7:0]) - 128;
            pocj_pkg::FMT_S16: return longint'($signed(raw[15:0]));
            pocj_pkg::FMT_S24: return longint'($signed(raw[23:0]));
            default: return longint'($signed(raw));
        endcase
    endfunction

    function automatic t_mixed_beat from_level(input longint lvl, input pocj_pkg::t_fmt f);
        longint      hi;
        longint      lo;
        t_mixed_beat b;
        hi = (longint'(1) <<< (fmt_bits(f) - 1)) - 1;
        lo = -(longint'(1) <<< (fmt_bits(f) - 1));
        b.clipped = 1'b0;
        if (lvl > hi) begin
            lvl = hi;
            b.clipped = 1'b1;
        end
        if (lvl < lo) begin
            lvl = lo;
            b.clipped = 1'b1;
        end
        if (f == pocj_pkg::FMT_U8) begin
            b.sample = 32'(lvl + 128);
        end else begin
            b.sample = 32'(lvl) & fmt_width_mask(f);
        end
        return b;
    endfunction

    function automatic int active_channels(input logic [pocj_pkg::CNT_CH_W-1:0] cc);
        if (cc == '0) return 1;
        if (cc > pocj_pkg::CNT_CH_W'(pocj_pkg::MAX_CH)) return pocj_pkg::MAX_CH;
        return int'(cc);
    endfunction

    function automatic void predict_joined_sample(
        input logic [pocj_pkg::SAMPLE_W-1:0] raw_in,
        input logic [pocj_pkg::REGION_W-1:0] region,
        input logic                          start
    );
        logic [pocj_pkg::SAMPLE_W-1:0] raw;
        t_mixed_beat                   b;
        longint                        den;
        longint                        t;
        longint                        h;
        longint                        num;
        longint                        mag;
        longint                        q;
        longint                        r;
        raw = raw_in & fmt_width_mask(cur_fmt);
        if (start) begin
            tail_wr    = 0;
            head_rd    = 0;
            head_frame = '0;
            head_ch    = 0;
        end
        if (region == pocj_pkg::REGION_TAIL) begin
            tail_mem[tail_wr]     = raw;
            slot_written[tail_wr] = 1'b1;
            tail_wr = (tail_wr + 1) % pocj_pkg::TAIL_DEPTH;
        end else if (region == pocj_pkg::REGION_HEAD) begin
            den = longint'(ovl_frames) + 1;
            t   = to_level(tail_mem[head_rd], cur_fmt);
            h   = to_level(raw, cur_fmt);
            num = t * den + (h - t) * (longint'(head_frame) + 1);
            mag = (num < 0) ? -num : num;
            q   = mag / den;
            r   = mag % den;
            // round half to even
            if (2 * r > den || (2 * r == den && q[0])) begin
                q = q + 1;
            end
            predicted_samples.push_back(from_level((num < 0) ? -q : q, cur_fmt));
            head_rd = (head_rd + 1) % pocj_pkg::TAIL_DEPTH;
            head_ch++;
            if (head_ch >= active_channels(ch_count)) begin
                head_ch    = 0;
                head_frame = head_frame + 1'b1;
            end
        end else begin
            b.sample  = raw;
            b.clipped = 1'b0;
            predicted_samples.push_back(b);
        end
    endfunction

    // random bits above the format, extremes or random bits within it
    function automatic logic [pocj_pkg::SAMPLE_W-1:0] pick_raw();
        logic [pocj_pkg::SAMPLE_W-1:0] m;
        logic [pocj_pkg::SAMPLE_W-1:0] top;
        logic [pocj_pkg::SAMPLE_W-1:0] v;
        m   = fmt_width_mask(cur_fmt);
        top = 32'd1 << (fmt_bits(cur_fmt) - 1);
        case ($urandom_range(5, 0))
            0:       v = m;
            1:       v = '0;
            2:       v = top;
            3:       v = top - 32'd1;
            default: v = $urandom;
        endcase
        return ($urandom & ~m) | (v & m);
    endfunction

    task automatic send_sample(
        input logic [pocj_pkg::SAMPLE_W-1:0] raw,
        input logic [pocj_pkg::REGION_W-1:0] region,
        input logic                          start
    );
        int idx;
        idx = start ? 0 : head_rd;
        // never read a slot that no tail beat has filled
        if (region == pocj_pkg::REGION_HEAD && !slot_written[idx]) begin
            region = pocj_pkg::REGION_TAIL;
        end
        while ($urandom_range(99, 0) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.sample_raw <= raw;
        in_if.region     <= region;
        in_if.part_start <= start;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_joined_sample(raw, region, start);
    endtask

    task automatic cfg_beat(
        input logic [pocj_pkg::CFG_IDX_W-1:0]  idx,
        input logic [pocj_pkg::CFG_DATA_W-1:0] data
    );
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            pocj_pkg::CFG_OVERLAP:  ovl_frames = data;
            pocj_pkg::CFG_CHANNELS: ch_count   = data[pocj_pkg::CNT_CH_W-1:0];
            pocj_pkg::CFG_FORMAT:   cur_fmt    = pocj_pkg::t_fmt'(data[pocj_pkg::FMT_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic write_joiner_regs(
        input logic [pocj_pkg::OVL_W-1:0]    ovl,
        input logic [pocj_pkg::CNT_CH_W-1:0] ch,
        input pocj_pkg::t_fmt                fmt
    );
        cfg_beat(pocj_pkg::CFG_OVERLAP, ovl);
        cfg_beat(pocj_pkg::CFG_CHANNELS, {9'($urandom), ch});
        cfg_beat(pocj_pkg::CFG_FORMAT, {11'($urandom), fmt});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        in_if.valid <= 1'b0;
        while (predicted_samples.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (predicted_samples.size() != 0) begin
            $error("%0d predicted samples never came out", predicted_samples.size());
            fail_count += predicted_samples.size();
            predicted_samples.delete();
        end
        // let a trailing tail write settle
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 77; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 77; end
            default: begin src_idle_pct = 27; snk_stall_pct = 27; end
        endcase
    endtask

    // one part: head beats over the stored tail, some body, then a new tail
    task automatic send_part(inout int sent);
        int ch;
        int head_frames;
        int tail_frames;
        int n_body;
        int k;
        bit first;
        ch = active_channels(ch_count);
        if (ovl_frames < 6) begin
            head_frames = $urandom_range(int'(ovl_frames) + 3, 0);
            tail_frames = $urandom_range(int'(ovl_frames) + 1, 1);
        end else begin
            head_frames = $urandom_range(6, 0);
            tail_frames = $urandom_range(6, 1);
        end
        n_body = $urandom_range(3, 0);
        first  = 1'b1;
        for (k = 0; k < head_frames * ch; k++) begin
            send_sample(pick_raw(), pocj_pkg::REGION_HEAD, first);
            first = 1'b0;
        end
        for (k = 0; k < n_body; k++) begin
            send_sample(pick_raw(), pocj_pkg::REGION_BODY, first);
            first = 1'b0;
        end
        for (k = 0; k < tail_frames * ch; k++) begin
            send_sample(pick_raw(), pocj_pkg::REGION_TAIL, first);
            first = 1'b0;
        end
        sent += (head_frames + tail_frames) * ch + n_body;
    endtask

    task automatic test_reset_defaults();
        set_idling(0);
        send_sample(32'h1234_8000, pocj_pkg::REGION_BODY, 1'b1);
        send_sample(32'h0000_7FFF, pocj_pkg::REGION_TAIL, 1'b0);
        send_sample(32'hFFFF_8000, pocj_pkg::REGION_TAIL, 1'b0);
        send_sample(32'h0000_1000, pocj_pkg::REGION_TAIL, 1'b0);
        send_sample(32'h0000_0000, pocj_pkg::REGION_TAIL, 1'b0);
        // ties at half a step on the negative side
        send_sample(32'h0000_8000, pocj_pkg::REGION_HEAD, 1'b1);
        send_sample(32'h0000_7FFF, pocj_pkg::REGION_HEAD, 1'b0);
        send_sample(32'h0000_0003, pocj_pkg::REGION_HEAD, 1'b0);
        send_sample(32'hFFFF_FFFF, pocj_pkg::REGION_HEAD, 1'b0);
        send_sample(32'hABCD_FFFF, pocj_pkg::REGION_RSVD, 1'b0);
        send_sample(32'hFFFF_FFFF, pocj_pkg::REGION_BODY, 1'b0);
        wait_idle();
    endtask

    task automatic test_zero_overlap_u8();
        set_idling(0);
        write_joiner_regs(13'd0, 4'd0, pocj_pkg::FMT_U8);
        send_sample(32'h0000_00FF, pocj_pkg::REGION_TAIL, 1'b1);
        send_sample(32'h0000_0000, pocj_pkg::REGION_TAIL, 1'b0);
        send_sample(32'h0000_0080, pocj_pkg::REGION_HEAD, 1'b1);
        // second frame extrapolates past full gain and saturates
        send_sample(32'h0000_00FF, pocj_pkg::REGION_HEAD, 1'b0);
        send_sample(32'hFFFF_FF7F, pocj_pkg::REGION_BODY, 1'b0);
        wait_idle();
    endtask

    task automatic test_format_change();
        set_idling(0);
        write_joiner_regs(13'd2, 4'd15, pocj_pkg::FMT_S32);
        send_sample(32'h8000_0000, pocj_pkg::REGION_TAIL, 1'b1);
        send_sample(32'h7FFF_FFFF, pocj_pkg::REGION_TAIL, 1'b0);
        send_sample(32'h00FF_FFFF, pocj_pkg::REGION_TAIL, 1'b0);
        send_sample(32'h0080_0000, pocj_pkg::REGION_TAIL, 1'b0);
        wait_idle();
        // stored bits are decoded in the new format
        write_joiner_regs(13'd2, 4'd15, pocj_pkg::FMT_S24);
        send_sample(32'h007F_FFFF, pocj_pkg::REGION_HEAD, 1'b1);
        send_sample(32'hFF80_0000, pocj_pkg::REGION_HEAD, 1'b0);
        send_sample(32'h0000_0000, pocj_pkg::REGION_HEAD, 1'b0);
        send_sample(32'h00FF_FFFF, pocj_pkg::REGION_HEAD, 1'b0);
        send_sample(32'h1234_5678, pocj_pkg::REGION_BODY, 1'b0);
        wait_idle();
    endtask

    task automatic test_long_overlap();
        int k;
        set_idling(0);
        write_joiner_regs(13'd4095, 4'd1, pocj_pkg::FMT_S16);
        for (k = 0; k < LONG_ITEMS; k++) begin
            send_sample(pick_raw(), pocj_pkg::REGION_TAIL, k == 0);
        end
        // small gains against a wide denominator
        for (k = 0; k < LONG_ITEMS; k++) begin
            send_sample(pick_raw(), pocj_pkg::REGION_HEAD, k == 0);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int ovl_set [6] = '{0, 8191, 1, 4096, 3, 2};
        int ch_set [6]  = '{1, 8, 0, 15, 2, 3};
        int p;
        int sent;
        int k;
        int burst;
        for (p = 0; p < RAND_PHASES; p++) begin
            set_idling(p % 4);
            if (p < 6) begin
                write_joiner_regs(pocj_pkg::OVL_W'(ovl_set[p]),
                                  pocj_pkg::CNT_CH_W'(ch_set[p]),
                                  pocj_pkg::t_fmt'(p % 4));
            end else begin
                write_joiner_regs(pocj_pkg::OVL_W'($urandom_range(12, 0)),
                                  pocj_pkg::CNT_CH_W'($urandom_range(15, 0)),
                                  pocj_pkg::t_fmt'($urandom_range(3, 0)));
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(99, 0) < 85) begin
                    send_part(sent);
                end else begin
                    burst = $urandom_range(4, 1);
                    for (k = 0; k < burst; k++) begin
                        send_sample($urandom, pocj_pkg::REGION_W'($urandom_range(3, 0)),
                                    $urandom_range(7, 0) == 0);
                    end
                    sent += burst;
                end
            end
            wait_idle();
        end
    endtask

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (predicted_samples.size() == 0) begin
                fail_count++;
                $error("unexpected beat: sample_out %h clipped %b",
                       out_if.sample_out, out_if.clipped);
            end else begin
                want_beat = predicted_samples.pop_front();
                if (out_if.sample_out !== want_beat.sample) begin
                    fail_count++;
                    $error("sample_out: expected %h, got %h",
                           want_beat.sample, out_if.sample_out);
                end
                if (out_if.clipped !== want_beat.clipped) begin
                    fail_count++;
                    $error("clipped: expected %b, got %b",
                           want_beat.clipped, out_if.clipped);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        fail_count    = 0;
        cycle_count   = 0;
        tail_wr       = 0;
        head_rd       = 0;
        head_frame    = '0;
        head_ch       = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.sample_raw <= '0;
        in_if.region     <= pocj_pkg::REGION_BODY;
        in_if.part_start <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= pocj_pkg::CFG_OVERLAP;
        cfg_if.data      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_overlap_u8();
        test_format_change();
        test_long_overlap();
        test_random_traffic();

        wait_idle();
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
